>>> design/chacha20_stream_cipher_macros.svh
// Assertion macros shared by the cipher's checker.
// No dependencies; include by bare file name.
`ifndef CHACHA20_STREAM_CIPHER_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet in reset
`define CHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet in reset
`define CHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/chacha_pkg.sv
// Shared types, constants and round functions for the ChaCha20 word cipher.
// No dependencies; imported by every module of the block.
`default_nettype none

package chacha_pkg;

  localparam int WORDS       = 16;
  localparam int POS_W       = 4;
  localparam int DBL_ROUNDS  = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [3:0][31:0] SIGMA = {32'h6b206574, 32'h79622d32,
                                        32'h3320646e, 32'h61707865};

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_01   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_23   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_45   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_67   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_INIT = 3'd6;

  typedef struct packed {
    logic [31:0] text_word;
    logic        is_final;
  } in_word_t;

  typedef struct packed {
    logic [31:0] cipher_word;
    logic        final_out;
  } out_word_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  // Controller to datapath
  typedef struct packed {
    logic take_item;
    logic load_init;
    logic round_en;
    logic round_second;
    logic round_diag;
    logic ks_write;
    logic out_write;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pos_zero;
    logic out_free;
  } dp_status_t;

  // One half of a quarter round: first half rotates by 16/12, second by 8/7
  function automatic quad_t qr_half(input quad_t q, input logic second);
    logic [31:0] a1, d1, c1, b1, dx, bx;
    a1 = q.a + q.b;
    dx = q.d ^ a1;
    d1 = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
    c1 = q.c + d1;
    bx = q.b ^ c1;
    b1 = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
    return '{a: a1, b: b1, c: c1, d: d1};
  endfunction

  function automatic logic [31:0] byte_swap(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

`default_nettype wire

>>> design/chacha_ctrl.sv
// Sequencer for the ChaCha20 word cipher: handshake, round steps, emit.
// Depends on chacha_pkg for the command and status structs.
`default_nettype none

module chacha_ctrl
  import chacha_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DBL_ROUNDS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam int STEPS  = 4 * DOUBLE_ROUNDS;
  localparam int STEP_W = $clog2(STEPS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ROUND = 4'b0010,
    S_FEED  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_nxt        = state_r;
    step_nxt         = step_r;
    cmd              = '0;
    cmd.round_second = step_r[0];
    cmd.round_diag   = step_r[1];
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.take_item = 1'b1;
          step_nxt      = '0;
          if (status.pos_zero) begin
            cmd.load_init = 1'b1;
            state_nxt     = S_ROUND;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_W'(STEPS - 1)) begin
          state_nxt = S_FEED;
        end
      end
      S_FEED: begin
        cmd.ks_write = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          cmd.out_write = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/chacha_dp.sv
// Datapath of the ChaCha20 word cipher: configuration, working state,
// keystream block, position and counter, output register. Uses chacha_pkg.
`default_nettype none

module chacha_dp
  import chacha_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_word_t              in_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output out_word_t             out_data,
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  logic [63:0]      key01_r, key23_r, key45_r, key67_r, nonce01_r;
  logic [31:0]      nonce2_r, ctr_init_r, blk_ctr_r;
  logic [POS_W-1:0] pos_r;
  logic [31:0]      text_r;
  logic             final_r;
  logic             out_valid_r;
  out_word_t        out_r, out_nxt;

  logic [31:0] init [WORDS];
  logic [31:0] work_r [WORDS];
  logic [31:0] work_nxt [WORDS];
  logic [31:0] ks_r [WORDS];
  quad_t       qc [4];
  quad_t       qd [4];

  // Block input state
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init[i] = SIGMA[i];
    end
    init[4]  = key01_r[63:32];
    init[5]  = key01_r[31:0];
    init[6]  = key23_r[63:32];
    init[7]  = key23_r[31:0];
    init[8]  = key45_r[63:32];
    init[9]  = key45_r[31:0];
    init[10] = key67_r[63:32];
    init[11] = key67_r[31:0];
    init[12] = blk_ctr_r;
    init[13] = nonce01_r[63:32];
    init[14] = nonce01_r[31:0];
    init[15] = nonce2_r;
  end

  // Four quarter-round halves, column and diagonal variants
  for (genvar g = 0; g < 4; g++) begin : g_qr
    localparam int DB = 4 + ((g + 1) % 4);
    localparam int DC = 8 + ((g + 2) % 4);
    localparam int DD = 12 + ((g + 3) % 4);
    assign qc[g] = qr_half('{a: work_r[g], b: work_r[4+g], c: work_r[8+g],
                             d: work_r[12+g]}, cmd.round_second);
    assign qd[g] = qr_half('{a: work_r[g], b: work_r[DB], c: work_r[DC],
                             d: work_r[DD]}, cmd.round_second);
  end

  // Scatter the results back to their state words
  always_comb begin
    for (int i = 0; i < WORDS; i++) begin
      work_nxt[i] = work_r[i];
    end
    for (int g = 0; g < 4; g++) begin
      if (cmd.round_diag) begin
        work_nxt[g]                  = qd[g].a;
        work_nxt[4 + ((g + 1) & 3)]  = qd[g].b;
        work_nxt[8 + ((g + 2) & 3)]  = qd[g].c;
        work_nxt[12 + ((g + 3) & 3)] = qd[g].d;
      end else begin
        work_nxt[g]      = qc[g].a;
        work_nxt[4 + g]  = qc[g].b;
        work_nxt[8 + g]  = qc[g].c;
        work_nxt[12 + g] = qc[g].d;
      end
    end
  end

  // Working state and keystream block
  always_ff @(posedge clk) begin
    if (cmd.load_init) begin
      work_r <= init;
    end else if (cmd.round_en) begin
      work_r <= work_nxt;
    end
    if (cmd.ks_write) begin
      for (int i = 0; i < WORDS; i++) begin
        ks_r[i] <= byte_swap(work_r[i] + init[i]);
      end
    end
    if (cmd.take_item) begin
      text_r  <= in_data.text_word;
      final_r <= in_data.is_final;
    end
    if (cmd.out_write) begin
      out_r <= out_nxt;
    end
  end

  assign out_nxt.cipher_word = text_r ^ ks_r[pos_r];
  assign out_nxt.final_out   = final_r;

  // Configuration, position and block counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r    <= '0;
      key23_r    <= '0;
      key45_r    <= '0;
      key67_r    <= '0;
      nonce01_r  <= '0;
      nonce2_r   <= '0;
      ctr_init_r <= '0;
      blk_ctr_r  <= '0;
      pos_r      <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_KEY_01:   key01_r   <= cfg_data;
          REG_KEY_23:   key23_r   <= cfg_data;
          REG_KEY_45:   key45_r   <= cfg_data;
          REG_KEY_67:   key67_r   <= cfg_data;
          REG_NONCE_01: nonce01_r <= cfg_data;
          REG_NONCE_2:  nonce2_r  <= cfg_data[31:0];
          REG_CTR_INIT: begin
            ctr_init_r <= cfg_data[31:0];
            blk_ctr_r  <= cfg_data[31:0];
          end
          default: ;
        endcase
      end
      if (cmd.out_write) begin
        if (final_r) begin
          // end of message: restart at the programmed counter
          pos_r     <= '0;
          blk_ctr_r <= ctr_init_r;
        end else if (pos_r == POS_W'(WORDS - 1)) begin
          pos_r     <= '0;
          blk_ctr_r <= blk_ctr_r + 32'd1;
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_write) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign status.pos_zero = (pos_r == '0);
  assign status.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

>>> design/chacha20_stream_cipher.sv
// Top level of the ChaCha20 word cipher: sequencer plus datapath.
// Depends on chacha_pkg, chacha_ctrl and chacha_dp.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-----------------------------
//   input   | in_valid, in_ready, in_data    | text word and final marker
//   result  | out_valid, out_ready, out_data | cipher word and final marker
//   config  | cfg_wr_en, cfg_index, cfg_data | one register per write
//
// One word at a time. A word at block position 0 is accepted, then runs the
// rounds, one half quarter round step per cycle on four lanes, then the
// feed-forward add, and is then emitted. Other words go from accept to emit.
// Reset (synchronous, rst_n low) clears configuration, counter and position.
// A held output register stalls the emit step; the next word is taken once
// the current one sits in the output register.
`default_nettype none

module chacha20_stream_cipher
  import chacha_pkg::*;
#(
  parameter int DOUBLE_ROUNDS = DBL_ROUNDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  chacha_ctrl #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  chacha_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

>>> design/chacha_chk.sv
// Port-level checker for the ChaCha20 word cipher, bound to the top level.
// Depends on chacha_pkg and chacha20_stream_cipher_macros.svh.
`default_nettype none
`include "chacha20_stream_cipher_macros.svh"

module chacha_chk
  import chacha_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_word_t             out_data
);

  logic       in_acc, out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count words taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  `CHA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word changed while stalled")
  `CHA_ASSERT_NOW(a_no_spurious, out_valid, pend_r != 2'd0, "result word with no input word behind it")
  `CHA_ASSERT_NOW(a_pend_bound, 1'b1, pend_r != 2'd3, "more than two words in flight")
  `CHA_ASSERT_NEXT(a_one_at_time, in_acc, !in_ready, "second word taken before the first was emitted")

endmodule

bind chacha20_stream_cipher chacha_chk u_chk (.*);

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the ChaCha20 word cipher: directed words, then random messages
// under several key, nonce and counter settings. Needs chacha_pkg and chacha20_stream_cipher.
module testbench
  import chacha_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROUNDS2    = DBL_ROUNDS;
  localparam int QUIET_MAX  = 2000;
  localparam int PHASE_WORDS = 225;

  // Expected cipher words, worked out from the text words the block has taken
  class cipher_predictor;
    bit [63:0] key_01, key_23, key_45, key_67, nonce_01;
    bit [31:0] nonce_2, counter_base;
    bit [31:0] keystream [16];
    bit [31:0] mix [16];
    bit [3:0]  word_pos;
    bit [31:0] block_ctr;
    out_word_t pending_cipher [$];
    int mismatches;
    int words_checked;
    int blocks_built;
    int counter_wraps;

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        REG_KEY_01:   key_01 = data;
        REG_KEY_23:   key_23 = data;
        REG_KEY_45:   key_45 = data;
        REG_KEY_67:   key_67 = data;
        REG_NONCE_01: nonce_01 = data;
        REG_NONCE_2:  nonce_2 = data[31:0];
        REG_CTR_INIT: begin
          counter_base = data[31:0];
          block_ctr = data[31:0];
        end
        default: ;
      endcase
    endfunction

    function bit [31:0] rotl(bit [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
      mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
      mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
    endfunction

    // Run the block function on the current key, nonce and counter
    function void build_block();
      bit [31:0] seed [16];
      bit [31:0] sum;
      for (int i = 0; i < 4; i++) seed[i] = SIGMA[i];
      seed[4]  = key_01[63:32];   seed[5]  = key_01[31:0];
      seed[6]  = key_23[63:32];   seed[7]  = key_23[31:0];
      seed[8]  = key_45[63:32];   seed[9]  = key_45[31:0];
      seed[10] = key_67[63:32];   seed[11] = key_67[31:0];
      seed[12] = block_ctr;
      seed[13] = nonce_01[63:32]; seed[14] = nonce_01[31:0];
      seed[15] = nonce_2;
      for (int i = 0; i < 16; i++) mix[i] = seed[i];
      for (int r = 0; r < ROUNDS2; r++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) begin
        sum = mix[i] + seed[i];
        keystream[i] = {sum[7:0], sum[15:8], sum[23:16], sum[31:24]};
      end
      blocks_built++;
    endfunction

    // Note a text word the block has accepted and queue its cipher word
    function void take_text(in_word_t w);
      out_word_t exp_word;
      if (word_pos == 4'd0) build_block();
      exp_word.cipher_word = w.text_word ^ keystream[word_pos];
      exp_word.final_out = w.is_final;
      pending_cipher.push_back(exp_word);
      if (w.is_final) begin
        word_pos = 4'd0;
        block_ctr = counter_base;
      end else if (word_pos == 4'd15) begin
        word_pos = 4'd0;
        if (block_ctr == 32'hFFFF_FFFF) counter_wraps++;
        block_ctr = block_ctr + 32'd1;
      end else begin
        word_pos = word_pos + 4'd1;
      end
    endfunction

    // Compare an emitted word with the oldest expectation
    function void check_cipher(out_word_t got);
      out_word_t exp_word;
      if (pending_cipher.size() == 0) begin
        $display("%0t: unexpected word cipher=%h final=%b", $time, got.cipher_word,
                 got.final_out);
        mismatches++;
        return;
      end
      exp_word = pending_cipher.pop_front();
      words_checked++;
      if (got.cipher_word !== exp_word.cipher_word) begin
        $display("%0t: cipher_word expected %h actual %h", $time, exp_word.cipher_word,
                 got.cipher_word);
        mismatches++;
      end
      if (got.final_out !== exp_word.final_out) begin
        $display("%0t: final_out expected %b actual %b", $time, exp_word.final_out,
                 got.final_out);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cipher_predictor cipher_model;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;
  int words_sent = 0;
  int messages_sent = 0;
  int settings_used = 0;

  chacha20_stream_cipher #(.DOUBLE_ROUNDS(ROUNDS2)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check emitted words and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) cipher_model.check_cipher(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX) begin
          $display("%0t: no word moved for %0d cycles", $time, QUIET_MAX);
          $display("testbench failed");
          $finish;
        end
      end
    end
  end

  // Offer one text word, with an optional gap first; return at the next falling edge
  task send_word(bit [31:0] text, bit fin);
    in_word_t w;
    w.text_word = text;
    w.is_final = fin;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    cipher_model.take_text(w);
    words_sent++;
    if (fin) messages_sent++;
    @(negedge clk);
  endtask

  // Hold the input low until every expected word has come out
  task drain();
    in_valid <= 1'b0;
    while (cipher_model.pending_cipher.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all seven registers on consecutive cycles
  task program_cfg(bit [63:0] k01, bit [63:0] k23, bit [63:0] k45, bit [63:0] k67,
                   bit [63:0] n01, bit [31:0] n2, bit [31:0] cs);
    bit [63:0] vals [7];
    vals = '{k01, k23, k45, k67, n01, {32'd0, n2}, {32'd0, cs}};
    for (int i = 0; i < 7; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      cipher_model.write_reg(CFG_IDX_W'(i), vals[i]);
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  function int pick_length();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, 3);
      1:       return $urandom_range(15, 17);
      default: return $urandom_range(4, 48);
    endcase
  endfunction

  task send_message(int len);
    for (int i = 0; i < len; i++) send_word($urandom, i == len - 1);
  endtask

  function bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    int phase_words;
    int len;
    bit [31:0] cs;
    bit [31:0] patterns [6];
    cipher_model = new();
    patterns = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'h8000_0000, 32'h0000_0001};

    // Hold reset low at the start, then release it
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: a one-word message, final at block position zero
    send_word(32'h0000_0000, 1'b1);
    drain();

    // Counting key, counter start one: a full block ending on final, then a short one
    program_cfg(64'h00010203_04050607, 64'h08090a0b_0c0d0e0f, 64'h10111213_14151617,
                64'h18191a1b_1c1d1e1f, 64'h00000009_0000004a, 32'h0000_0000, 32'h0000_0001);
    for (int i = 0; i < 16; i++) send_word(i < 6 ? patterns[i] : $urandom, i == 15);
    send_message(3);
    drain();

    // Random messages under a series of settings; the last one runs without idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: program_cfg('0, '0, '0, '0, '0, '0, '0);
        1: program_cfg('1, '1, '1, '1, '1, '1, '1);
        2: program_cfg(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom,
                       32'hFFFF_FFFE);
        default: begin
          cs = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3);
          program_cfg(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom, cs);
        end
      endcase
      idle_on = (ph != 7);
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        len = pick_length();
        send_message(len);
        phase_words += len;
      end
      // Leave a message open so the next settings land mid-block
      if (ph == 3 || ph == 5) begin
        len = $urandom_range(5, 20);
        for (int i = 0; i < len; i++) send_word($urandom, 1'b0);
      end
      drain();
    end

    repeat (8) @(negedge clk);
    if (cipher_model.pending_cipher.size() != 0) begin
      $display("%0t: %0d expected words never came out", $time,
               cipher_model.pending_cipher.size());
      cipher_model.mismatches += cipher_model.pending_cipher.size();
    end
    $display("Covered %0d words in %0d closed messages under %0d register settings.",
             words_sent, messages_sent, settings_used);
    $display("Checked %0d words over %0d keystream blocks, %0d counter wraps, %0d errors.",
             cipher_model.words_checked, cipher_model.blocks_built,
             cipher_model.counter_wraps, cipher_model.mismatches);
    if (cipher_model.mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
